@@ rtl/tss_pkg.sv @@
// Shared types, codes and sizes of the transmission shift scheduler.
package tss_pkg;

    localparam int NUM_BANDS  = 4;
    localparam int SHIFT_COLS = 5;
    localparam int LOCK_COLS  = 3;
    localparam int BAND_IW    = $clog2(NUM_BANDS);
    localparam int SHIFT_DEPTH = NUM_BANDS * SHIFT_COLS;
    localparam int LOCK_DEPTH  = NUM_BANDS * LOCK_COLS;
    localparam int SHIFT_AW    = $clog2(SHIFT_DEPTH);
    localparam int LOCK_AW     = $clog2(LOCK_DEPTH);

    localparam logic [15:0] HOLD_RESET     = 16'd750;
    localparam logic [7:0]  DEBOUNCE_RESET = 8'd50;

    localparam logic [2:0] LOCK_MIN_GEAR = 3'd4;
    localparam logic [2:0] TOP_GEAR      = 3'd6;
    localparam logic [2:0] LOW_GEAR      = 3'd1;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] SEL_UP     = 3'd0;
    localparam logic [2:0] SEL_DOWN   = 3'd1;
    localparam logic [2:0] SEL_LOCK   = 3'd2;
    localparam logic [2:0] SEL_UNLOCK = 3'd3;
    localparam logic [2:0] SEL_EDGE   = 3'd4;

    localparam logic CFG_HOLD     = 1'b0;
    localparam logic CFG_DEBOUNCE = 1'b1;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_UNLOCK = 3'd1,
        CMD_LOCK   = 3'd2,
        CMD_DOWN   = 3'd3,
        CMD_UP     = 3'd4
    } t_cmd;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [6:0]  throttle_percent;
        logic [15:0] speed_hz;
        logic [2:0]  current_gear;
        logic        converter_locked;
        logic [2:0]  table_select;
        logic [2:0]  table_row;
        logic [2:0]  table_col;
        logic [15:0] table_value;
    } t_in;

    typedef struct packed {
        t_cmd       command;
        logic [2:0] throttle_band;
        logic       held;
    } t_out;

    typedef struct packed {
        logic       we;
        logic [2:0] idx;
        logic [6:0] value;
    } t_edge_wr;

    typedef struct packed {
        logic        we;
        logic [2:0]  sel;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] value;
    } t_tbl_wr;

    typedef struct packed {
        logic       re;
        logic [2:0] band;
        logic [2:0] gear;
    } t_tbl_rd;

    typedef struct packed {
        logic [15:0] up;
        logic [15:0] down;
        logic [15:0] lock;
        logic [15:0] unlock;
    } t_thr;

endpackage

@@ rtl/tss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tss_band.sv @@
// Throttle band edges, band index and edge debounce counter.
module tss_band (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tss_pkg::t_edge_wr i_edge_wr,
    input  logic [6:0]        i_tps,
    input  logic [7:0]        i_debounce,
    input  logic              i_step,
    output logic [2:0]        o_band,
    output logic [2:0]        o_band_next
);

    logic [6:0] r_edge [tss_pkg::NUM_BANDS-1];
    logic [2:0] r_band;
    logic [7:0] r_cnt;
    logic [2:0] n_band;
    logic [7:0] n_cnt;

    logic [tss_pkg::NUM_BANDS-1:0] gt;
    logic [tss_pkg::BAND_IW-1:0]   band_lo;
    logic [tss_pkg::BAND_IW-1:0]   band_m1;
    logic                          up_past;
    logic                          dn_past;
    logic [8:0]                    cnt_inc;

    for (genvar i = 0; i < tss_pkg::NUM_BANDS - 1; i++) begin : g_edge
        always_ff @(posedge i_clk) begin
            if (i_edge_wr.we && i_edge_wr.idx == 3'(i)) begin
                r_edge[i] <= i_edge_wr.value;
            end
        end
        assign gt[i] = i_tps > r_edge[i];
    end
    // top band has no upper edge
    assign gt[tss_pkg::NUM_BANDS-1] = 1'b0;

    always_comb begin
        band_lo = r_band[tss_pkg::BAND_IW-1:0];
        band_m1 = band_lo - tss_pkg::BAND_IW'(1);
        up_past = gt[band_lo];
        dn_past = (r_band != 3'd0) && !gt[band_m1];
        cnt_inc = {1'b0, r_cnt} + 9'd1;
        n_band  = r_band;
        n_cnt   = 8'd0;
        if (up_past || dn_past) begin
            if (cnt_inc >= {1'b0, i_debounce}) begin
                n_band = up_past ? r_band + 3'd1 : r_band - 3'd1;
            end else begin
                n_cnt = cnt_inc[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= 3'd0;
            r_cnt  <= 8'd0;
        end else if (i_step) begin
            r_band <= n_band;
            r_cnt  <= n_cnt;
        end
    end

    assign o_band      = r_band;
    assign o_band_next = n_band;

endmodule

@@ rtl/tss_tables.sv @@
// Shift and converter threshold tables held in four synchronous RAMs.
module tss_tables (
    input  logic             i_clk,
    input  tss_pkg::t_tbl_wr i_wr,
    input  tss_pkg::t_tbl_rd i_rd,
    output tss_pkg::t_thr    o_thr
);

    logic row_ok;
    logic shift_col_ok;
    logic lock_col_ok;
    logic we_up;
    logic we_down;
    logic we_lock;
    logic we_unlock;

    logic [tss_pkg::SHIFT_AW-1:0] shift_waddr;
    logic [tss_pkg::LOCK_AW-1:0]  lock_waddr;
    logic [tss_pkg::SHIFT_AW-1:0] up_raddr;
    logic [tss_pkg::SHIFT_AW-1:0] down_raddr;
    logic [tss_pkg::LOCK_AW-1:0]  lock_raddr;
    logic [2:0]                   up_col;
    logic [2:0]                   down_col;
    logic [2:0]                   lock_col;

    always_comb begin
        row_ok       = int'(i_wr.row) < tss_pkg::NUM_BANDS;
        shift_col_ok = int'(i_wr.col) < tss_pkg::SHIFT_COLS;
        lock_col_ok  = int'(i_wr.col) < tss_pkg::LOCK_COLS;
        we_up     = 1'b0;
        we_down   = 1'b0;
        we_lock   = 1'b0;
        we_unlock = 1'b0;
        if (i_wr.we && row_ok) begin
            unique case (i_wr.sel)
                tss_pkg::SEL_UP:     we_up     = shift_col_ok;
                tss_pkg::SEL_DOWN:   we_down   = shift_col_ok;
                tss_pkg::SEL_LOCK:   we_lock   = lock_col_ok;
                tss_pkg::SEL_UNLOCK: we_unlock = lock_col_ok;
                default: ;
            endcase
        end
        shift_waddr = tss_pkg::SHIFT_AW'(i_wr.row) * tss_pkg::SHIFT_AW'(tss_pkg::SHIFT_COLS)
                    + tss_pkg::SHIFT_AW'(i_wr.col);
        lock_waddr  = tss_pkg::LOCK_AW'(i_wr.row) * tss_pkg::LOCK_AW'(tss_pkg::LOCK_COLS)
                    + tss_pkg::LOCK_AW'(i_wr.col);
    end

    // Gear is already clamped to 1..6; columns that do not exist read column 0.
    always_comb begin
        up_col   = (i_rd.gear <= 3'd5) ? i_rd.gear - 3'd1 : 3'd0;
        down_col = (i_rd.gear >= 3'd2) ? i_rd.gear - 3'd2 : 3'd0;
        lock_col = (i_rd.gear >= tss_pkg::LOCK_MIN_GEAR) ?
                   i_rd.gear - tss_pkg::LOCK_MIN_GEAR : 3'd0;
        up_raddr   = tss_pkg::SHIFT_AW'(i_rd.band) * tss_pkg::SHIFT_AW'(tss_pkg::SHIFT_COLS)
                   + tss_pkg::SHIFT_AW'(up_col);
        down_raddr = tss_pkg::SHIFT_AW'(i_rd.band) * tss_pkg::SHIFT_AW'(tss_pkg::SHIFT_COLS)
                   + tss_pkg::SHIFT_AW'(down_col);
        lock_raddr = tss_pkg::LOCK_AW'(i_rd.band) * tss_pkg::LOCK_AW'(tss_pkg::LOCK_COLS)
                   + tss_pkg::LOCK_AW'(lock_col);
    end

    tss_ram #(.WIDTH(16), .DEPTH(tss_pkg::SHIFT_DEPTH)) u_up (
        .i_clk   (i_clk),
        .i_we    (we_up),
        .i_waddr (shift_waddr),
        .i_wdata (i_wr.value),
        .i_re    (i_rd.re),
        .i_raddr (up_raddr),
        .o_rdata (o_thr.up)
    );

    tss_ram #(.WIDTH(16), .DEPTH(tss_pkg::SHIFT_DEPTH)) u_down (
        .i_clk   (i_clk),
        .i_we    (we_down),
        .i_waddr (shift_waddr),
        .i_wdata (i_wr.value),
        .i_re    (i_rd.re),
        .i_raddr (down_raddr),
        .o_rdata (o_thr.down)
    );

    tss_ram #(.WIDTH(16), .DEPTH(tss_pkg::LOCK_DEPTH)) u_lock (
        .i_clk   (i_clk),
        .i_we    (we_lock),
        .i_waddr (lock_waddr),
        .i_wdata (i_wr.value),
        .i_re    (i_rd.re),
        .i_raddr (lock_raddr),
        .o_rdata (o_thr.lock)
    );

    tss_ram #(.WIDTH(16), .DEPTH(tss_pkg::LOCK_DEPTH)) u_unlock (
        .i_clk   (i_clk),
        .i_we    (we_unlock),
        .i_waddr (lock_waddr),
        .i_wdata (i_wr.value),
        .i_re    (i_rd.re),
        .i_raddr (lock_raddr),
        .o_rdata (o_thr.unlock)
    );

endmodule

@@ rtl/transmission_shift_scheduler.sv @@
// Top level of the transmission shift scheduler.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes control steps and
// table writes; every transfer yields exactly one result on the output channel
// (o_out_valid / i_out_stall / o_out_data), in order.
// The band update, hold check and threshold RAM reads happen in the transfer cycle;
// the RAM data is compared in the compare stage and the command is registered into
// the output register when that stage advances. One item per cycle is sustained
// unless the receiver stalls; the hold check of an item sees the action of the
// item just ahead of it through a forward path from the compare stage.
// Table writes land in the RAMs at their transfer edge, so a step right behind
// a write reads the new value.
// When the receiver stalls a valid result, the output register holds it, the compare
// stage holds its item and RAM data, and o_in_stall rises while that stage is full.
// Reset (i_rst_n low, synchronous) empties both stages, clears band, debounce
// counter and last action time, and restores hold 750 ms and debounce 50.
// Threshold tables and band edges are not cleared; load them before use.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect at once.
module transmission_shift_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tss_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tss_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data
);

    typedef struct packed {
        logic        skip;
        logic        held;
        logic [31:0] now;
        logic [15:0] hz;
        logic [2:0]  gear;
        logic        locked;
        logic [2:0]  band;
    } t_s1;

    logic [15:0]   r_hold;
    logic [7:0]    r_debounce;
    logic [31:0]   r_last;
    logic          r_s1_valid;
    t_s1           r_s1;
    logic          r_out_valid;
    tss_pkg::t_out r_out;

    logic              accept;
    logic              s1_go;
    logic              is_step;
    logic              fwd;
    logic [31:0]       diff_prev;
    logic [31:0]       diff_last;
    logic              held_in;
    logic              step;
    logic [2:0]        gear_in;
    logic [2:0]        band;
    logic [2:0]        band_next;
    tss_pkg::t_edge_wr edge_wr;
    tss_pkg::t_tbl_wr  tbl_wr;
    tss_pkg::t_tbl_rd  tbl_rd;
    tss_pkg::t_thr     thr;
    tss_pkg::t_cmd     cmd;
    logic              act;
    logic              up;
    logic              down;

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_step    = i_in_data.operation == tss_pkg::OP_STEP;

    // command decision on RAM data
    always_comb begin
        cmd  = tss_pkg::CMD_NONE;
        up   = (r_s1.gear <= 3'd5) && (r_s1.hz > thr.up);
        down = (r_s1.gear >= 3'd2) && (r_s1.hz < thr.down);
        if (!r_s1.skip) begin
            if (r_s1.gear < tss_pkg::LOCK_MIN_GEAR) begin
                if (r_s1.locked) cmd = tss_pkg::CMD_UNLOCK;
            end else if (r_s1.locked) begin
                if (r_s1.hz < thr.unlock) cmd = tss_pkg::CMD_UNLOCK;
            end else begin
                if (r_s1.hz > thr.lock) cmd = tss_pkg::CMD_LOCK;
            end
            if (cmd == tss_pkg::CMD_NONE) begin
                if (down)    cmd = tss_pkg::CMD_DOWN;
                else if (up) cmd = tss_pkg::CMD_UP;
            end
        end
        act = cmd != tss_pkg::CMD_NONE;
    end

    // hold check; an action still in the compare stage overrides r_last
    always_comb begin
        fwd       = r_s1_valid && act;
        diff_prev = i_in_data.now_ms - r_s1.now;
        diff_last = i_in_data.now_ms - r_last;
        held_in   = is_step && (fwd ? (diff_prev < {16'd0, r_hold})
                                    : (diff_last < {16'd0, r_hold}));
        step      = accept && is_step && !held_in;
        if (i_in_data.current_gear == 3'd0) begin
            gear_in = tss_pkg::LOW_GEAR;
        end else if (i_in_data.current_gear > tss_pkg::TOP_GEAR) begin
            gear_in = tss_pkg::TOP_GEAR;
        end else begin
            gear_in = i_in_data.current_gear;
        end
    end

    always_comb begin
        edge_wr.we    = accept && !is_step && i_in_data.table_select == tss_pkg::SEL_EDGE;
        edge_wr.idx   = i_in_data.table_row;
        edge_wr.value = i_in_data.table_value[6:0];
        tbl_wr.we     = accept && !is_step;
        tbl_wr.sel    = i_in_data.table_select;
        tbl_wr.row    = i_in_data.table_row;
        tbl_wr.col    = i_in_data.table_col;
        tbl_wr.value  = i_in_data.table_value;
        tbl_rd.re     = step;
        tbl_rd.band   = band_next;
        tbl_rd.gear   = gear_in;
    end

    tss_band u_band (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge_wr   (edge_wr),
        .i_tps       (i_in_data.throttle_percent),
        .i_debounce  (r_debounce),
        .i_step      (step),
        .o_band      (band),
        .o_band_next (band_next)
    );

    tss_tables u_tables (
        .i_clk (i_clk),
        .i_wr  (tbl_wr),
        .i_rd  (tbl_rd),
        .o_thr (thr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= tss_pkg::HOLD_RESET;
            r_debounce  <= tss_pkg::DEBOUNCE_RESET;
            r_last      <= 32'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tss_pkg::CFG_HOLD:     r_hold     <= i_cfg_data;
                    tss_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s1_go && act) begin
                r_last <= r_s1.now;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.skip   <= !step;
            r_s1.held   <= held_in;
            r_s1.now    <= i_in_data.now_ms;
            r_s1.hz     <= i_in_data.speed_hz;
            r_s1.gear   <= gear_in;
            r_s1.locked <= i_in_data.converter_locked;
            r_s1.band   <= step ? band_next : band;
        end
        if (s1_go) begin
            r_out.command       <= cmd;
            r_out.throttle_band <= r_s1.band;
            r_out.held          <= r_s1.held;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ verif/shift_schedule_checker.sv @@
// Checker for the shift scheduler: tracks both channels, predicts each result and compares.
module shift_schedule_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  tss_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  tss_pkg::t_out i_out_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    output int            o_pending,
    output int            o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    logic [15:0] hold_ms;
    logic [7:0]  debounce;
    logic [2:0]  band;
    logic [7:0]  edge_cnt;
    logic [31:0] last_ms;

    logic [6:0]  band_edge  [NUM_BANDS-1];
    logic [15:0] up_tab     [NUM_BANDS][SHIFT_COLS];
    logic [15:0] down_tab   [NUM_BANDS][SHIFT_COLS];
    logic [15:0] lock_tab   [NUM_BANDS][LOCK_COLS];
    logic [15:0] unlock_tab [NUM_BANDS][LOCK_COLS];

    t_out shift_decisions [$];
    int   mismatches = 0;

    // Applies one item to the local copy of the scheduler state and returns its result.
    function automatic t_out decide_item(input t_in it);
        logic [31:0] since;
        logic [2:0]  gear;
        logic [8:0]  steps;
        logic        go_up;
        logic        go_down;
        t_out        res;
        res.command = CMD_NONE;
        res.held    = 1'b0;
        if (it.operation == OP_WRITE) begin
            case (it.table_select)
                SEL_EDGE: begin
                    if (it.table_row < NUM_BANDS - 1)
                        band_edge[it.table_row] = it.table_value[6:0];
                end
                SEL_UP: begin
                    if (it.table_row < NUM_BANDS && it.table_col < SHIFT_COLS)
                        up_tab[it.table_row][it.table_col] = it.table_value;
                end
                SEL_DOWN: begin
                    if (it.table_row < NUM_BANDS && it.table_col < SHIFT_COLS)
                        down_tab[it.table_row][it.table_col] = it.table_value;
                end
                SEL_LOCK: begin
                    if (it.table_row < NUM_BANDS && it.table_col < LOCK_COLS)
                        lock_tab[it.table_row][it.table_col] = it.table_value;
                end
                SEL_UNLOCK: begin
                    if (it.table_row < NUM_BANDS && it.table_col < LOCK_COLS)
                        unlock_tab[it.table_row][it.table_col] = it.table_value;
                end
                default: ;
            endcase
        end else begin
            since = it.now_ms - last_ms;
            if (since < {16'd0, hold_ms}) begin
                res.held = 1'b1;
            end else begin
                go_up   = 1'b0;
                go_down = 1'b0;
                if (band < NUM_BANDS - 1 && it.throttle_percent > band_edge[band])
                    go_up = 1'b1;
                else if (band > 0 && it.throttle_percent <= band_edge[band - 3'd1])
                    go_down = 1'b1;
                if (go_up || go_down) begin
                    steps = {1'b0, edge_cnt} + 9'd1;
                    if (steps >= {1'b0, debounce}) begin
                        band  = go_up ? band + 3'd1 : band - 3'd1;
                        steps = '0;
                    end
                    edge_cnt = steps[7:0];
                end else begin
                    edge_cnt = '0;
                end

                gear = it.current_gear;
                if (gear < LOW_GEAR)
                    gear = LOW_GEAR;
                if (gear > TOP_GEAR)
                    gear = TOP_GEAR;

                // converter first; below the lock gear a locked converter always opens
                if (gear < LOCK_MIN_GEAR) begin
                    if (it.converter_locked)
                        res.command = CMD_UNLOCK;
                end else if (it.converter_locked) begin
                    if (it.speed_hz < unlock_tab[band][gear - LOCK_MIN_GEAR])
                        res.command = CMD_UNLOCK;
                end else if (it.speed_hz > lock_tab[band][gear - LOCK_MIN_GEAR]) begin
                    res.command = CMD_LOCK;
                end

                if (res.command == CMD_NONE) begin
                    if (gear >= 3'd2 && it.speed_hz < down_tab[band][gear - 3'd2])
                        res.command = CMD_DOWN;
                    else if (gear <= SHIFT_COLS && it.speed_hz > up_tab[band][gear - 3'd1])
                        res.command = CMD_UP;
                end
                if (res.command != CMD_NONE)
                    last_ms = it.now_ms;
            end
        end
        res.throttle_band = band;
        return res;
    endfunction

    always @(posedge i_clk) begin : track_results
        t_out  want;
        string want_s;
        string got_s;
        if (!i_rst_n) begin
            hold_ms  = HOLD_RESET;
            debounce = DEBOUNCE_RESET;
            band     = '0;
            edge_cnt = '0;
            last_ms  = '0;
            shift_decisions.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HOLD)
                    hold_ms = i_cfg_data;
                else
                    debounce = i_cfg_data[7:0];
            end
            if (i_out_valid && !i_out_stall) begin
                got_s = $sformatf("cmd=%0d band=%0d held=%0d", i_out_data.command,
                                  i_out_data.throttle_band, i_out_data.held);
                if (shift_decisions.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, got %s", $time, got_s);
                end else begin
                    want = shift_decisions.pop_front();
                    want_s = $sformatf("cmd=%0d band=%0d held=%0d", want.command,
                                       want.throttle_band, want.held);
                    if (i_out_data.command !== want.command
                            || i_out_data.throttle_band !== want.throttle_band
                            || i_out_data.held !== want.held) begin
                        mismatches++;
                        $display("%0t: result mismatch: expected %s, got %s",
                                 $time, want_s, got_s);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                shift_decisions.push_back(decide_item(i_in_data));
        end
        o_pending <= shift_decisions.size();
        o_errors  <= mismatches;
    end

endmodule

@@ verif/tb_transmission_shift_scheduler.sv @@
// Testbench top for the shift scheduler: table load, directed steps, random phases, verdict.
module tb_transmission_shift_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import tss_pkg::*;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         in_data  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_we   = 1'b0;
    logic        cfg_idx  = CFG_HOLD;
    logic [15:0] cfg_data = '0;
    int          pending;
    int          errors;

    logic [31:0] now_ms    = '0;
    int          hold_cur  = HOLD_RESET;
    int          gap_pct   = 0;
    int          stall_pct = 0;
    int          stall_left = 0;
    int          throttle_target = 50;

    always #10 clk = ~clk;

    transmission_shift_scheduler uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    shift_schedule_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // receiver back-pressure in bursts, started at random per stall_pct
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (rst_n && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    function automatic t_in write_item(input logic [2:0] sel, input logic [2:0] row,
                                       input logic [2:0] col, input logic [15:0] val);
        t_in it;
        it.operation        = OP_WRITE;
        it.now_ms           = $urandom;
        it.throttle_percent = 7'($urandom_range(0, 100));
        it.speed_hz         = 16'($urandom);
        it.current_gear     = 3'($urandom);
        it.converter_locked = 1'($urandom);
        it.table_select     = sel;
        it.table_row        = row;
        it.table_col        = col;
        it.table_value      = val;
        return it;
    endfunction

    function automatic t_in step_item(input logic [31:0] stamp, input logic [6:0] tps,
                                      input logic [15:0] hz, input logic [2:0] gear,
                                      input logic locked);
        t_in it;
        it.operation        = OP_STEP;
        it.now_ms           = stamp;
        it.throttle_percent = tps;
        it.speed_hz         = hz;
        it.current_gear     = gear;
        it.converter_locked = locked;
        it.table_select     = 3'($urandom_range(0, 4));
        it.table_row        = 3'($urandom);
        it.table_col        = 3'($urandom_range(0, 4));
        it.table_value      = 16'($urandom);
        return it;
    endfunction

    // one transfer on the input channel, with an optional idle burst ahead of it
    task automatic push_item(input t_in it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] hold, input logic [7:0] deb);
        drain();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HOLD;
        cfg_data <= hold;
        @(posedge clk);
        cfg_idx  <= CFG_DEBOUNCE;
        cfg_data <= {8'd0, deb};
        @(posedge clk);
        cfg_we   <= 1'b0;
        hold_cur = hold;
    endtask

    task automatic run_phase(input logic [15:0] hold, input logic [7:0] deb,
                             input int gap, input int stall, input int count);
        t_in         it;
        logic [6:0]  tps;
        logic [15:0] hz;
        logic [2:0]  sel;
        logic [15:0] val;
        set_config(hold, deb);
        gap_pct = gap;
        stall_pct <= stall;
        repeat (count) begin
            if ($urandom_range(0, 99) < 15) begin
                sel = 3'($urandom_range(0, 4));
                if (sel == SEL_EDGE)
                    val = {9'($urandom), 7'($urandom_range(0, 100))};
                else if ($urandom_range(0, 4) != 0)
                    val = 16'($urandom_range(0, 4000));
                else
                    val = 16'($urandom);
                it = write_item(sel,
                                ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 3))
                                                            : 3'($urandom),
                                3'($urandom_range(0, 4)), val);
            end else begin
                // throttle dwells on a target so the band debounce can complete
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       throttle_target = 0;
                        1:       throttle_target = 100;
                        default: throttle_target = $urandom_range(0, 100);
                    endcase
                end
                tps = ($urandom_range(0, 99) < 85) ? 7'(throttle_target)
                                                   : 7'($urandom_range(0, 100));
                case ($urandom_range(0, 9))
                    0:       hz = 16'd0;
                    1:       hz = 16'hFFFF;
                    2:       hz = 16'($urandom);
                    default: hz = 16'($urandom_range(0, 4000));
                endcase
                case ($urandom_range(0, 9))
                    0:       now_ms = now_ms;
                    1:       now_ms = now_ms + 32'(hold_cur);
                    2:       now_ms = now_ms + 32'(hold_cur) - 32'd1;
                    3:       now_ms = now_ms + $urandom;
                    default: now_ms = now_ms + $urandom_range(0, 2 * hold_cur + 2);
                endcase
                it = step_item(now_ms, tps, hz, 3'($urandom), 1'($urandom));
            end
            push_item(it);
            if ($urandom_range(0, 199) == 0)
                drain();
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct = 20;
        stall_pct <= 20;

        // every table entry gets a value before any step can read it
        for (int r = 0; r < NUM_BANDS - 1; r++)
            push_item(write_item(SEL_EDGE, 3'(r), 3'd0,
                                 {9'($urandom), 7'(15 + 30 * r + $urandom_range(0, 10))}));
        for (int r = 0; r < NUM_BANDS; r++) begin
            for (int c = 0; c < SHIFT_COLS; c++) begin
                push_item(write_item(SEL_UP, 3'(r), 3'(c), 16'($urandom_range(0, 4000))));
                push_item(write_item(SEL_DOWN, 3'(r), 3'(c), 16'($urandom_range(0, 4000))));
            end
            for (int c = 0; c < LOCK_COLS; c++) begin
                push_item(write_item(SEL_LOCK, 3'(r), 3'(c), 16'($urandom_range(1, 4000))));
                push_item(write_item(SEL_UNLOCK, 3'(r), 3'(c), 16'($urandom_range(1, 4000))));
            end
        end

        // hold window edges after reset, with the reset configuration
        push_item(step_item(32'd0, 7'd0, 16'd0, 3'd4, 1'b0));
        push_item(step_item(32'd749, 7'd0, 16'd0, 3'd4, 1'b0));
        push_item(step_item(32'd750, 7'd100, 16'd1000, 3'd3, 1'b1));
        now_ms = 32'd750;
        // gear clamping, low-gear unlock, lock hysteresis, shift choices
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'd0, 3'd0, 1'b0));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'hFFFF, 3'd0, 1'b0));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'hFFFF, 3'd7, 1'b0));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'd0, 3'd7, 1'b1));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'hFFFF, 3'd4, 1'b1));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'd0, 3'd5, 1'b0));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'd0, 3'd2, 1'b0));
        now_ms += 750; push_item(step_item(now_ms, 7'd0, 16'hFFFF, 3'd3, 1'b0));
        // table writes, including addresses that must be ignored
        push_item(write_item(SEL_UP, 3'd3, 3'd4, 16'hFFFF));
        push_item(write_item(SEL_DOWN, 3'd5, 3'd0, 16'hFFFF));
        push_item(write_item(SEL_LOCK, 3'd0, 3'd4, 16'd0));
        push_item(write_item(SEL_UNLOCK, 3'd7, 3'd3, 16'd0));
        push_item(write_item(SEL_EDGE, 3'd3, 3'd0, 16'h007F));
        push_item(write_item(SEL_EDGE, 3'd0, 3'd7, {9'h1A5, 7'd10}));
        // timestamp wrap
        now_ms = 32'hFFFF_FFF0; push_item(step_item(now_ms, 7'd50, 16'd2000, 3'd6, 1'b0));
        now_ms = 32'h0000_0100; push_item(step_item(now_ms, 7'd50, 16'd2000, 3'd6, 1'b1));

        // zero hold and zero debounce: the band moves on every step past an edge
        set_config(16'd0, 8'd0);
        repeat (4) push_item(step_item(now_ms, 7'd100, 16'd2000, 3'd5, 1'b0));
        repeat (4) push_item(step_item(now_ms, 7'd0, 16'd2000, 3'd5, 1'b1));

        run_phase(16'd750, 8'd1, 30, 30, 250);
        run_phase(16'd0, 8'd2, 0, 0, 150);
        run_phase(16'hFFFF, 8'hFF, 40, 40, 150);
        run_phase(16'($urandom_range(0, 2000)), 8'($urandom_range(1, 8)), 20, 50, 250);
        run_phase(16'd100, 8'd3, 50, 20, 250);
        run_phase(16'($urandom), 8'($urandom_range(1, 255)), 30, 30, 150);
        run_phase(16'd20, 8'd1, 25, 25, 250);
        run_phase(16'd500, 8'd2, 0, 0, 250);

        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_band.sv
rtl/tss_tables.sv
rtl/transmission_shift_scheduler.sv
verif/shift_schedule_checker.sv
verif/tb_transmission_shift_scheduler.sv
